// ===== rtl/packet_release_pacer_macros.svh =====
// assertion macros for the packet release pacer
// expects clk and rst in the scope of every use
`ifndef PACKET_RELEASE_PACER_MACROS_SVH
`define PACKET_RELEASE_PACER_MACROS_SVH

// property checked on every clock edge outside reset
`define PRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PRP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/prp_pkg.sv =====
// shared types and constants for the packet release pacer
// no dependencies
package prp_pkg;

  // fraction bits of the fixed point next-time and rate registers
  localparam int FRAC_BITS = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_PACKET = 2'd0,
    REQ_START  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_LIMIT  = 2'd3
  } req_t;

  // pacing modes
  typedef enum logic [1:0] {
    MODE_REPLAY   = 2'd0,
    MODE_PKT_RATE = 2'd1,
    MODE_BIT_RATE = 2'd2,
    MODE_NOGAP    = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PACE_MODE    = 2'd0,
    CFG_REPLAY_SCALE = 2'd1,
    CFG_PACKET_GAP   = 2'd2,
    CFG_BYTE_TIME    = 2'd3
  } cfg_idx_t;

  // what the back part has to do with one item
  typedef enum logic [1:0] {
    KIND_HELD  = 2'd0,
    KIND_FIRST = 2'd1,
    KIND_PACE  = 2'd2
  } kind_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic        hit;
    logic [63:0] now;
    logic [63:0] diff;
    logic [15:0] prev_len;
  } task_t;

  // configuration seen by the back part
  typedef struct packed {
    mode_t       mode;
    logic [31:0] scale;
    logic [63:0] gap;
    logic [31:0] byte_time;
  } cfg_t;

endpackage

// ===== rtl/prp_front.sv =====
// front part: classifies requests and keeps the pacer control state
// depends on prp_pkg
module prp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [1:0]      req_type,
  input  logic [63:0]     now_ns,
  input  logic [63:0]     capture_ts_ns,
  input  logic [15:0]     pkt_len,
  input  logic [31:0]     limit_count,
  output prp_pkg::task_t  task_out
);

  logic        running, running_next;
  logic        awaiting_first, awaiting_first_next;
  logic [63:0] ref_stamp, ref_stamp_next;
  logic [15:0] prev_len, prev_len_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] remaining_dec;

  assign remaining_dec = remaining - 32'd1;

  // classification and state update for one transfer
  always_comb begin
    running_next        = running;
    awaiting_first_next = awaiting_first;
    ref_stamp_next      = ref_stamp;
    prev_len_next       = prev_len;
    remaining_next      = remaining;
    task_out.kind       = prp_pkg::KIND_HELD;
    task_out.hit        = 1'b0;
    task_out.now        = now_ns;
    task_out.diff       = capture_ts_ns - ref_stamp;
    task_out.prev_len   = prev_len;
    case (prp_pkg::req_t'(req_type))
      prp_pkg::REQ_START: begin
        running_next        = 1'b1;
        awaiting_first_next = 1'b1;
      end
      prp_pkg::REQ_STOP: begin
        running_next = 1'b0;
      end
      prp_pkg::REQ_LIMIT: begin
        remaining_next = limit_count;
      end
      prp_pkg::REQ_PACKET: begin
        if (running) begin
          task_out.kind = awaiting_first ? prp_pkg::KIND_FIRST : prp_pkg::KIND_PACE;
          awaiting_first_next = 1'b0;
          ref_stamp_next      = capture_ts_ns;
          prev_len_next       = pkt_len;
          // packet limit countdown
          if (remaining != 32'd0) begin
            remaining_next = remaining_dec;
            if (remaining_dec == 32'd0) begin
              running_next = 1'b0;
              task_out.hit = 1'b1;
            end
          end
        end
      end
      default: begin
        running_next = running;
      end
    endcase
  end

  // control state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      awaiting_first <= 1'b1;
      ref_stamp      <= 64'd0;
      prev_len       <= 16'd0;
      remaining      <= 32'd0;
    end else if (accept) begin
      running        <= running_next;
      awaiting_first <= awaiting_first_next;
      ref_stamp      <= ref_stamp_next;
      prev_len       <= prev_len_next;
      remaining      <= remaining_next;
    end
  end

endmodule

// ===== rtl/prp_queue.sv =====
// short queue of classified items between front and back
// depends on prp_pkg and packet_release_pacer_macros.svh
`include "packet_release_pacer_macros.svh"

module prp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  prp_pkg::task_t  push_data,
  input  logic            pop,
  output prp_pkg::task_t  head,
  output logic            empty,
  output logic            full
);

  prp_pkg::task_t                   entries [prp_pkg::QUEUE_DEPTH];
  logic [prp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [prp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [prp_pkg::QCNT_W-1:0]       count;

  assign empty = (count == prp_pkg::QCNT_W'(0));
  assign full  = (count == prp_pkg::QCNT_W'(prp_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == prp_pkg::QPTR_W'(prp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + prp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == prp_pkg::QPTR_W'(prp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + prp_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + prp_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - prp_pkg::QCNT_W'(1);
      end
    end
  end

  `PRP_NEVER(a_no_push_full, push && full, "queue written while full")
  `PRP_NEVER(a_no_pop_empty, pop && empty, "queue read while empty")
  `PRP_NEVER(a_count_range, count > prp_pkg::QCNT_W'(prp_pkg::QUEUE_DEPTH), "queue count overflow")

endmodule

// ===== rtl/prp_back.sv =====
// back part: gap multiply, next-time accumulation and result register
// depends on prp_pkg and packet_release_pacer_macros.svh
`include "packet_release_pacer_macros.svh"

module prp_back (
  input  logic            clk,
  input  logic            rst,
  input  prp_pkg::cfg_t   cfg,
  input  prp_pkg::task_t  head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     release_ns,
  output logic            released,
  output logic            limit_reached
);

  localparam int FB = prp_pkg::FRAC_BITS;

  logic        adv;

  // stage 1: partial products
  logic            v1;
  prp_pkg::kind_t  kind1;
  logic            hit1;
  logic [63:0]     now1;
  logic [63:0]     pp_lo1;
  logic [31:0]     pp_hi1;
  logic [47:0]     len_prod1;
  logic [63:0]     pp_lo_c;
  logic [31:0]     pp_hi_c;
  logic [47:0]     len_prod_c;

  // stage 2: selected gap
  logic            v2;
  prp_pkg::kind_t  kind2;
  logic            hit2;
  logic [63:0]     now2;
  logic [63:0]     gap2;
  logic [63:0]     gap_c;

  // stage 3: accumulated next-time
  logic            v3;
  prp_pkg::kind_t  kind3;
  logic            hit3;
  logic [63:0]     now3;
  logic [63:0]     nt3;
  logic [63:0]     next_time;
  logic [63:0]     nt_c;
  logic            first3;

  // output stage
  logic [63:0]     whole_ns;
  logic [63:0]     rel_c;

  // the whole pipe moves unless a finished result is held
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !empty;

  // multiplications, low 64 bits of the replay product are enough
  assign pp_lo_c    = 64'(head.diff[31:0]) * 64'(cfg.scale);
  assign pp_hi_c    = head.diff[63:32] * cfg.scale;
  assign len_prod_c = 48'(head.prev_len) * 48'(cfg.byte_time);

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1     <= head.kind;
      hit1      <= head.hit;
      now1      <= head.now;
      pp_lo1    <= pp_lo_c;
      pp_hi1    <= pp_hi_c;
      len_prod1 <= len_prod_c;
    end
  end

  // gap for the current mode
  always_comb begin
    case (cfg.mode)
      prp_pkg::MODE_REPLAY:   gap_c = pp_lo1 + {pp_hi1, 32'd0};
      prp_pkg::MODE_PKT_RATE: gap_c = cfg.gap;
      prp_pkg::MODE_BIT_RATE: gap_c = 64'(len_prod1);
      default:                gap_c = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2 <= kind1;
      hit2  <= hit1;
      now2  <= now1;
      gap2  <= gap_c;
    end
  end

  // next-time accumulator, loaded from head time on a first item, one add per paced item
  always_comb begin
    case (kind2)
      prp_pkg::KIND_FIRST: nt_c = {now2[63-FB:0], FB'(0)};
      prp_pkg::KIND_PACE:  nt_c = next_time + gap2;
      default:             nt_c = next_time;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_time <= 64'd0;
    end else if (adv && v2) begin
      next_time <= nt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind3 <= kind2;
      hit3  <= hit2;
      now3  <= now2;
      nt3   <= nt_c;
    end
  end

  // release time of a released item: next-time floored, never before head time; held items give zero
  assign whole_ns = 64'(nt3 >> FB);
  assign first3   = v3 && (kind3 == prp_pkg::KIND_FIRST);

  always_comb begin
    case (kind3)
      prp_pkg::KIND_FIRST: rel_c = now3;
      prp_pkg::KIND_PACE:  rel_c = (whole_ns < now3) ? now3 : whole_ns;
      default:             rel_c = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      release_ns    <= rel_c;
      released      <= (kind3 != prp_pkg::KIND_HELD);
      limit_reached <= hit3;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  `PRP_ASSERT(a_hit_implies_release, (out_valid && limit_reached) |-> released, "hit on held item")
  `PRP_ASSERT(a_held_zero, (out_valid && !released) |-> (release_ns == 64'd0), "held item time")
  `PRP_ASSERT(a_first_at_head, (adv && first3) |=> (release_ns == $past(now3)), "first not at head")

endmodule

// ===== rtl/packet_release_pacer.sv =====
// Packet release pacer: one request is taken per clock while in_stall is low; each gives one
// result, in request order. Throughput is one item per cycle unless out_stall is high, set by the
// back part's next-time accumulator; a four-entry queue between classifier and arithmetic pipe
// absorbs out_stall, then in_stall rises. Configuration registers are written by the user through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block does not enforce it.
// top level: configuration registers, front classifier, queue and back pipe
// depends on prp_pkg, prp_front, prp_queue and prp_back
module packet_release_pacer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] now_ns,
  input  logic [63:0] capture_ts_ns,
  input  logic [15:0] pkt_len,
  input  logic [31:0] limit_count,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] release_ns,
  output logic        released,
  output logic        limit_reached
);

  prp_pkg::cfg_t  cfg;
  prp_pkg::task_t task_in;
  prp_pkg::task_t head;
  logic           accept;
  logic           q_empty;
  logic           q_full;
  logic           q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= prp_pkg::MODE_REPLAY;
      cfg.scale     <= 32'(64'd1 << prp_pkg::FRAC_BITS);
      cfg.gap       <= 64'd0;
      cfg.byte_time <= 32'd0;
    end else if (cfg_we) begin
      case (prp_pkg::cfg_idx_t'(cfg_index))
        prp_pkg::CFG_PACE_MODE:    cfg.mode      <= prp_pkg::mode_t'(cfg_data[1:0]);
        prp_pkg::CFG_REPLAY_SCALE: cfg.scale     <= cfg_data[31:0];
        prp_pkg::CFG_PACKET_GAP:   cfg.gap       <= cfg_data;
        prp_pkg::CFG_BYTE_TIME:    cfg.byte_time <= cfg_data[31:0];
        default:                   cfg.mode      <= cfg.mode;
      endcase
    end
  end

  // input transfer
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  prp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .req_type      (req_type),
    .now_ns        (now_ns),
    .capture_ts_ns (capture_ts_ns),
    .pkt_len       (pkt_len),
    .limit_count   (limit_count),
    .task_out      (task_in)
  );

  prp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (task_in),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  prp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .release_ns    (release_ns),
    .released      (released),
    .limit_reached (limit_reached)
  );

endmodule
